// ===== rtl/core/servo_sweep_scan_sequencer_assert.svh =====
// Assertion macros for the servo sweep scan sequencer.
`ifndef SERVO_SWEEP_SCAN_SEQUENCER_ASSERT_SVH
`define SERVO_SWEEP_SCAN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define SSS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sss assertion failed");

// Next-cycle implication, sampled on clk_i, idle during reset.
`define SSS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sss assertion failed");

`endif

// ===== rtl/core/sss_pkg.sv =====
// Shared constants and types for the servo sweep scan sequencer.
package sss_pkg;

  // entry store; depth is a power of two so the index wraps by truncation
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int STORE_W     = 11;  // {ir, distance}

  localparam int ANGLE_W   = 8;
  localparam int MS_W      = 16;
  localparam int DIST_W    = 10;
  localparam int MODE_W    = 2;
  localparam int PHASE_W   = 2;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // scan phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TOSTART = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SWEEP   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PARK    = 2'd3;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ANGLE_MIN = 2'd0;
  localparam logic [1:0] REG_ANGLE_MAX = 2'd1;
  localparam logic [1:0] REG_ANGLE_MID = 2'd2;
  localparam logic [1:0] REG_STEP_MS   = 2'd3;

  localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_MID_RST = 8'd90;
  localparam logic [MS_W-1:0]    STEP_MS_RST   = 16'd20;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_min;
    logic [ANGLE_W-1:0] angle_max;
    logic [ANGLE_W-1:0] angle_mid;
    logic [MS_W-1:0]    step_ms;
  } sss_cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle_q;
    logic [ANGLE_W-1:0]  angle_d;
    logic                moved;
    logic [PHASE_W-1:0]  phase_q;
    logic [PHASE_W-1:0]  phase_d;
    logic                done_q;
    logic                done_d;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_idx;
  } sss_ctrl_t;

endpackage

// ===== rtl/core/sss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sss_ctrl.sv =====
// Scan phase sequencer: phase, angle, step timer and done flag.
module sss_ctrl import sss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [MODE_W-1:0] mode_i,
  input  sss_cfg_t          cfg_i,
  output sss_ctrl_t         ctrl_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic [MS_W-1:0]    elapsed_q, elapsed_d;
  logic               done_q, done_d;
  logic               wr_en;
  logic [MS_W-1:0]    elapsed_inc;
  logic               step;
  logic [ANGLE_W-1:0] offset;

  assign elapsed_inc = (elapsed_q == {MS_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
  assign step        = (elapsed_inc >= cfg_i.step_ms);
  assign offset      = angle_q - cfg_i.angle_min;

  always_comb begin
    phase_d   = phase_q;
    angle_d   = angle_q;
    elapsed_d = elapsed_q;
    done_d    = done_q;
    wr_en     = 1'b0;
    case (mode_i)
      MODE_TICK: begin
        elapsed_d = elapsed_inc;
        case (phase_q)
          PH_TOSTART: begin
            if (angle_q > cfg_i.angle_min) begin
              if (step) begin
                elapsed_d = '0;
                angle_d   = angle_q - 1'b1;
              end
            end else begin
              phase_d   = PH_SWEEP;
              elapsed_d = '0;
            end
          end
          PH_SWEEP: begin
            if (angle_q >= cfg_i.angle_max) begin
              phase_d   = PH_PARK;
              done_d    = 1'b1;
              elapsed_d = '0;
            end else if (step) begin
              elapsed_d = '0;
              wr_en     = 1'b1;
              angle_d   = angle_q + 1'b1;
            end
          end
          PH_PARK: begin
            if (angle_q > cfg_i.angle_mid) begin
              if (step) begin
                elapsed_d = '0;
                angle_d   = angle_q - 1'b1;
              end
            end else begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_START: begin
        phase_d = PH_TOSTART;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      angle_q   <= ANGLE_MID_RST;
      elapsed_q <= '0;
      done_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      angle_q   <= angle_d;
      elapsed_q <= elapsed_d;
      done_q    <= done_d;
    end
  end

  assign ctrl_o.angle_q = angle_q;
  assign ctrl_o.angle_d = angle_d;
  assign ctrl_o.moved   = (angle_d != angle_q);
  assign ctrl_o.phase_q = phase_q;
  assign ctrl_o.phase_d = phase_d;
  assign ctrl_o.done_q  = done_q;
  assign ctrl_o.done_d  = done_d;
  assign ctrl_o.wr_en   = fire_i & wr_en;
  assign ctrl_o.wr_idx  = offset[STORE_AW-1:0];

endmodule

// ===== rtl/core/servo_sweep_scan_sequencer.sv =====
// Servo sweep scan sequencer top level: stream ports, APB registers, entry store.
// The result is registered: it appears on m_tvalid in the cycle after the input transfer.
// Throughput: one item per cycle while the sink takes results; the result register frees as it is taken.
// Reset (rst_ni low, asynchronous): idle phase, servo at 90, timer and done cleared,
// registers back to 0/180/90/20; the entry store is not cleared.
module servo_sweep_scan_sequencer import sss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // sonar_cm[9:0], ir_seen[10], read_index[18:11], zero
  input  logic [MODE_W-1:0] s_tuser,   // mode[1:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // servo_angle[7:0], angle_moved[8], phase[10:9],
                                       // results_waiting[11], read_distance[21:12],
                                       // read_ir[22], zero
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

`include "servo_sweep_scan_sequencer_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers, one per word at byte address 4*i.
  // ---------------------------------------------------------------------------
  sss_cfg_t   cfg_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_min <= ANGLE_MIN_RST;
      cfg_q.angle_max <= ANGLE_MAX_RST;
      cfg_q.angle_mid <= ANGLE_MID_RST;
      cfg_q.step_ms   <= STEP_MS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGLE_MIN: cfg_q.angle_min <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_MAX: cfg_q.angle_max <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_MID: cfg_q.angle_mid <= pwdata[ANGLE_W-1:0];
        REG_STEP_MS:   cfg_q.step_ms   <= pwdata[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ANGLE_MIN: prdata = {{(CFG_DW-ANGLE_W){1'b0}}, cfg_q.angle_min};
      REG_ANGLE_MAX: prdata = {{(CFG_DW-ANGLE_W){1'b0}}, cfg_q.angle_max};
      REG_ANGLE_MID: prdata = {{(CFG_DW-ANGLE_W){1'b0}}, cfg_q.angle_mid};
      REG_STEP_MS:   prdata = {{(CFG_DW-MS_W){1'b0}}, cfg_q.step_ms};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input unpacking and handshake. The result register takes a new item
  // whenever it is empty or its current result leaves in the same cycle.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  in_sonar;
  logic               in_ir;
  logic [ANGLE_W-1:0] in_ridx;
  logic               in_fire;
  logic               out_valid_q;

  assign in_sonar = s_tdata[9:0];
  assign in_ir    = s_tdata[10];
  assign in_ridx  = s_tdata[18:11];
  assign s_tready = ~out_valid_q | m_tready;
  assign in_fire  = s_tvalid & s_tready;

  // ---------------------------------------------------------------------------
  // Phase sequencer: all state moves at the input transfer edge.
  // ---------------------------------------------------------------------------
  sss_ctrl_t ctrl;

  sss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .mode_i (s_tuser),
    .cfg_i  (cfg_q),
    .ctrl_o (ctrl)
  );

  // ---------------------------------------------------------------------------
  // Entry store: written on sweep steps, read on read items. Its read
  // register doubles as the read fields of the result register, and only
  // loads on a read transfer so it holds under output stall.
  // ---------------------------------------------------------------------------
  logic               rd_en;
  logic [STORE_W-1:0] rd_data;

  assign rd_en = in_fire & (s_tuser == MODE_READ);

  sss_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl.wr_en),
    .waddr_i (ctrl.wr_idx),
    .wdata_i ({in_ir, in_sonar}),
    .re_i    (rd_en),
    .raddr_i (in_ridx[STORE_AW-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [ANGLE_W-1:0] res_angle_q;
  logic               res_moved_q;
  logic [PHASE_W-1:0] res_phase_q;
  logic               res_done_q;
  logic               res_rd_q;
  logic [DIST_W-1:0]  res_dist;
  logic               res_ir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_tready) begin
      out_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_angle_q <= ctrl.angle_d;
      res_moved_q <= ctrl.moved;
      res_phase_q <= ctrl.phase_d;
      res_done_q  <= ctrl.done_d;
      res_rd_q    <= (s_tuser == MODE_READ);
    end
  end

  // non-read items report zero read fields
  assign res_dist = res_rd_q ? rd_data[DIST_W-1:0] : '0;
  assign res_ir   = res_rd_q & rd_data[DIST_W];

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {1'b0, res_ir, res_dist, res_done_q, res_phase_q, res_moved_q,
                     res_angle_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // results_waiting is sticky until reset
  `SSS_ASSERT_NEXT(a_done_sticky, ctrl.done_q, ctrl.done_q)
  // the store is only written while sweeping
  `SSS_ASSERT_NOW(a_wr_in_sweep, ctrl.wr_en, ctrl.phase_q == PH_SWEEP)
  // start and read items never move the servo
  `SSS_ASSERT_NEXT(a_cmd_no_move, in_fire && (s_tuser != MODE_TICK), $stable(ctrl.angle_q))
  // a completed result is never dropped by a stalled sink
  `SSS_ASSERT_NOW(a_no_overrun, in_fire, !out_valid_q || m_tready)

endmodule

// ===== dv/servo_sweep_scan_sequencer_tb.sv =====
// Self-checking stream testbench for the servo sweep scan sequencer.
`timescale 1ns / 100ps

module servo_sweep_scan_sequencer_tb;
  import sss_pkg::*;

  // mode code 3 has no meaning; the block must leave its state alone
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // input transfer payload, lowest bit first: sonar_cm, ir_seen, read_index, zero fill
  typedef struct packed {
    logic [4:0]        pad;
    logic [7:0]        read_index;
    logic              ir_seen;
    logic [DIST_W-1:0] sonar_cm;
  } sweep_item_t;

  // result transfer payload, lowest bit first
  typedef struct packed {
    logic               pad;
    logic               read_ir;
    logic [DIST_W-1:0]  read_distance;
    logic               results_waiting;
    logic [PHASE_W-1:0] phase;
    logic               angle_moved;
    logic [ANGLE_W-1:0] servo_angle;
  } scan_status_t;

  // Tracks the sequencer state, predicts the status word of each transfer and
  // checks returned status words in order.
  class servo_scan_tracker;
    logic [ANGLE_W-1:0] lo_angle;
    logic [ANGLE_W-1:0] hi_angle;
    logic [ANGLE_W-1:0] park_angle;
    logic [MS_W-1:0]    step_len;
    logic [PHASE_W-1:0] phase;
    logic [ANGLE_W-1:0] angle;
    logic [MS_W-1:0]    ms_count;
    logic               sweep_done;
    logic [DIST_W-1:0]  range_mem [STORE_DEPTH];
    logic               beacon_mem [STORE_DEPTH];
    bit                 filled [STORE_DEPTH];
    scan_status_t       due_status [$];
    int unsigned        mismatches;

    function new();
      lo_angle   = ANGLE_MIN_RST;
      hi_angle   = ANGLE_MAX_RST;
      park_angle = ANGLE_MID_RST;
      step_len   = STEP_MS_RST;
      phase      = PH_IDLE;
      angle      = ANGLE_MID_RST;
      ms_count   = '0;
      sweep_done = 1'b0;
      mismatches = 0;
      foreach (filled[i]) filled[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_ANGLE_MIN: lo_angle   = value[ANGLE_W-1:0];
        REG_ANGLE_MAX: hi_angle   = value[ANGLE_W-1:0];
        REG_ANGLE_MID: park_angle = value[ANGLE_W-1:0];
        REG_STEP_MS:   step_len   = value[MS_W-1:0];
        default: ;
      endcase
    endfunction

    // a one-degree step falls due once the interval has run out; count restarts
    function bit step_due();
      if (ms_count >= step_len) begin
        ms_count = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void advance_ms(logic [DIST_W-1:0] cm, logic ir);
      logic [STORE_AW-1:0] slot;
      if (ms_count != '1) ms_count = ms_count + 1'b1;
      case (phase)
        PH_TOSTART: begin
          if (angle > lo_angle) begin
            if (step_due()) angle = angle - 1'b1;
          end else begin
            phase    = PH_SWEEP;
            ms_count = '0;
          end
        end
        PH_SWEEP: begin
          if (angle >= hi_angle) begin
            phase      = PH_PARK;
            sweep_done = 1'b1;
            ms_count   = '0;
          end else if (step_due()) begin
            slot = angle - lo_angle;  // wraps when the sweep starts below the minimum
            range_mem[slot]  = cm;
            beacon_mem[slot] = ir;
            filled[slot]     = 1'b1;
            angle = angle + 1'b1;
          end
        end
        PH_PARK: begin
          if (angle > park_angle) begin
            if (step_due()) angle = angle - 1'b1;
          end else begin
            phase = PH_IDLE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_item(logic [MODE_W-1:0] kind, sweep_item_t item);
      scan_status_t       want;
      logic [ANGLE_W-1:0] was;
      was  = angle;
      want = '0;
      case (kind)
        MODE_TICK:  advance_ms(item.sonar_cm, item.ir_seen);
        MODE_START: phase = PH_TOSTART;  // restart keeps angle and count
        MODE_READ: begin
          want.read_distance = range_mem[item.read_index[STORE_AW-1:0]];
          want.read_ir       = beacon_mem[item.read_index[STORE_AW-1:0]];
        end
        default: ;
      endcase
      want.servo_angle     = angle;
      want.angle_moved     = (angle != was);
      want.phase           = phase;
      want.results_waiting = sweep_done;
      due_status.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
      end
    endfunction

    function void check_status(logic [23:0] raw);
      scan_status_t got;
      scan_status_t want;
      got = raw;
      if (due_status.size() == 0) begin
        mismatches++;
        $display("%0t ns: status %h arrived with none expected", $time, raw);
        return;
      end
      want = due_status.pop_front();
      compare("servo_angle", 32'(want.servo_angle), 32'(got.servo_angle));
      compare("angle_moved", 32'(want.angle_moved), 32'(got.angle_moved));
      compare("phase", 32'(want.phase), 32'(got.phase));
      compare("results_waiting", 32'(want.results_waiting), 32'(got.results_waiting));
      compare("read_distance", 32'(want.read_distance), 32'(got.read_distance));
      compare("read_ir", 32'(want.read_ir), 32'(got.read_ir));
      compare("zero fill", 32'(want.pad), 32'(got.pad));
    endfunction

    // any entry already written since reset, so a read never hits a blank one
    function bit pick_filled(output logic [7:0] slot);
      int unsigned start;
      start = $urandom_range(STORE_DEPTH - 1);
      for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
        if (filled[(start + k) % STORE_DEPTH]) begin
          slot = 8'((start + k) % STORE_DEPTH);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int unsigned pending();
      return due_status.size();
    endfunction
  endclass

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata  = '0;  // sonar_cm[9:0], ir_seen[10], read_index[18:11], zero
  logic [MODE_W-1:0] s_tuser  = MODE_TICK;  // mode[1:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;  // servo_angle, angle_moved, phase, results_waiting,
                               // read_distance, read_ir, zero
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [CFG_AW-1:0] paddr    = '0;
  logic [CFG_DW-1:0] pwdata   = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // percentage of cycles in which each side holds off
  int unsigned src_idle_pct  = 30;
  int unsigned sink_idle_pct = 62;

  servo_scan_tracker tracker = new();

  servo_sweep_scan_sequencer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: check every completed transfer, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) tracker.check_status(m_tdata);
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Offers one item; returns at the edge where it was taken, tvalid still high
  // so a following item can go out back to back.
  task automatic send_item(input logic [MODE_W-1:0] kind, input logic [DIST_W-1:0] cm,
                           input logic ir, input logic [7:0] slot);
    sweep_item_t item;
    item = '{pad: '0, read_index: slot, ir_seen: ir, sonar_cm: cm};
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= item;
    do @(posedge clk_i); while (!s_tready);
    tracker.note_item(kind, item);
  endtask

  // stop offering and wait until every predicted status has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic load_setup(input int unsigned lo, input int unsigned hi,
                            input int unsigned park, input int unsigned step);
    write_reg(REG_ANGLE_MIN, lo);
    write_reg(REG_ANGLE_MAX, hi);
    write_reg(REG_ANGLE_MID, park);
    write_reg(REG_STEP_MS, step);
  endtask

  // Mostly ticks so scans run to completion; starts when idle, occasional
  // restarts mid-scan, reads of written entries and a few spare-code items.
  task automatic send_random(input int unsigned count, input int unsigned restart_pct);
    int unsigned       roll;
    logic [MODE_W-1:0] kind;
    logic [7:0]        slot;
    repeat (count) begin
      roll = $urandom_range(99);
      slot = 8'($urandom);
      if ((tracker.phase == PH_IDLE) ? (roll < 20) : (roll < restart_pct)) begin
        kind = MODE_START;
      end else if (roll >= 85 && tracker.pick_filled(slot)) begin
        kind = MODE_READ;
      end else if (roll >= 83 && roll < 85) begin
        kind = MODE_SPARE;
      end else begin
        kind = MODE_TICK;
      end
      send_item(kind, DIST_W'($urandom), 1'($urandom), slot);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: field extremes, spare code, start and restart
    send_item(MODE_TICK, '0, 1'b0, '0);
    send_item(MODE_TICK, '1, 1'b1, '1);
    send_item(MODE_SPARE, '1, 1'b1, '1);
    send_item(MODE_START, 10'h155, 1'b0, 8'haa);
    send_item(MODE_TICK, 10'h2aa, 1'b1, 8'h55);
    send_item(MODE_START, 10'h0f0, 1'b1, 8'h0f);
    settle();

    // zero interval mid-scan: every tick steps; short sweep fills entries 0..2
    load_setup(88, 91, 90, 0);
    for (int k = 0; k < 10; k++) send_item(MODE_TICK, k[0] ? '1 : '0, k[0], 8'(k));
    send_item(MODE_READ, '0, 1'b0, 8'd0);
    send_item(MODE_READ, '1, 1'b1, 8'd2);
    send_item(MODE_SPARE, '0, 1'b0, '0);
    settle();

    // parking below the minimum makes the next sweep wrap the store index
    load_setup(40, 60, 10, 1);
    send_random(90, 2);
    settle();  // hold off until the block has answered everything
    send_random(90, 2);
    settle();

    src_idle_pct  = 62;
    sink_idle_pct = 30;
    load_setup(20, 30, 0, 2);
    send_random(120, 2);
    settle();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_setup(0, 180, 180, 1);
    send_random(200, 0);
    settle();

    // minimum above maximum: the sweep ends at once
    load_setup(180, 0, 100, 1);
    send_random(60, 2);
    for (int k = 0; k < 1000 && tracker.phase != PH_IDLE; k++)
      send_item(MODE_TICK, DIST_W'($urandom), 1'($urandom), 8'($urandom));
    settle();

    // longest interval: the count keeps climbing and no step falls due
    load_setup(0, 180, 90, 16'hffff);
    repeat (30) send_item(MODE_TICK, DIST_W'($urandom), 1'($urandom), 8'($urandom));
    send_item(MODE_START, DIST_W'($urandom), 1'($urandom), 8'($urandom));
    repeat (3) send_item(MODE_TICK, DIST_W'($urandom), 1'($urandom), 8'($urandom));
    send_random(20, 0);
    settle();

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS servo_sweep_scan_sequencer");
    end else begin
      $display("FAIL servo_sweep_scan_sequencer");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL servo_sweep_scan_sequencer");
    $finish;
  end

endmodule
